>>> design/mfc_pkg.sv
`timescale 1ns / 1ps

package mfc_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [8:0]  POS_MAX  = 9'd511;
  localparam logic [8:0]  TCP_HDR  = 9'd6;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_CRC_ERR      = 3'd1,
    ST_EXCEPTION    = 3'd2,
    ST_UNKNOWN_FUNC = 3'd3,
    ST_TOO_SHORT    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN   = 2'd0,
    KIND_EXCEPTION = 2'd1,
    KIND_READ      = 2'd2,
    KIND_WRITE     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] data_byte;
    logic [7:0] payload_index;
    logic [7:0] unit_address;
    logic [6:0] function_code;
    logic [7:0] byte_count;
    logic [7:0] exception_code;
    status_t    status;
  } out_t;

  typedef struct packed {
    logic has_data;
    out_t data_res;
    logic has_status;
    out_t status_res;
  } entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic kind_t func_kind(input logic [7:0] fc);
    kind_t k;
    if (fc[7]) begin
      k = KIND_EXCEPTION;
    end else begin
      case (fc) inside
        FC_READ_HOLDING, FC_READ_INPUT: k = KIND_READ;
        FC_WRITE_SINGLE, FC_WRITE_MULTI: k = KIND_WRITE;
        default: k = KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

endpackage

>>> design/mfc_front.sv
`timescale 1ns / 1ps

module mfc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfc_pkg::in_t  in_data,
  input  logic          q_ready,
  output logic          q_push,
  output mfc_pkg::entry_t q_entry
);

  logic        frame_mode;
  logic [8:0]  pos;
  logic [15:0] crc_running;
  logic [15:0] crc_frozen;
  logic [7:0]  unit_seen;
  logic [7:0]  func_seen;
  logic [7:0]  count_seen;
  logic [7:0]  exc_seen;
  logic [7:0]  crc_low_rx;
  logic        crc_mismatch;

  logic [8:0]  pos_next;
  logic [15:0] crc_running_next;
  logic [15:0] crc_frozen_next;
  logic [7:0]  unit_seen_next;
  logic [7:0]  func_seen_next;
  logic [7:0]  count_seen_next;
  logic [7:0]  exc_seen_next;
  logic [7:0]  crc_low_rx_next;
  logic        crc_mismatch_next;

  logic           accept;
  logic           tcp;
  logic [8:0]     hdr;
  logic           in_pdu;
  logic [8:0]     p;
  logic [7:0]     rx;
  mfc_pkg::kind_t kind;
  logic [8:0]     body;
  logic [8:0]     need;
  logic [8:0]     got;
  logic [8:0]     cnt_full;
  logic           has_data;
  logic [8:0]     idx_full;
  mfc_pkg::status_t st;
  logic [7:0]     exc_out;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign tcp      = frame_mode;
  assign hdr      = tcp ? mfc_pkg::TCP_HDR : 9'd0;
  assign in_pdu   = (pos >= hdr);
  assign p        = pos - hdr;
  assign rx       = in_data.rx_byte;

  always_comb begin
    unit_seen_next  = unit_seen;
    func_seen_next  = func_seen;
    count_seen_next = count_seen;
    exc_seen_next   = exc_seen;
    if (in_pdu) begin
      if (p == 9'd0) begin
        unit_seen_next = rx;
      end else if (p == 9'd1) begin
        func_seen_next = rx;
      end else if (p == 9'd2) begin
        if (func_seen[7]) begin
          exc_seen_next = rx;
        end else if (mfc_pkg::func_kind(func_seen) == mfc_pkg::KIND_READ) begin
          count_seen_next = rx;
        end
      end
    end
  end

  assign kind = mfc_pkg::func_kind(func_seen_next);

  always_comb begin
    unique case (kind)
      mfc_pkg::KIND_EXCEPTION: body = 9'd3;
      mfc_pkg::KIND_READ:      body = 9'd3 + {1'b0, count_seen_next};
      default:                 body = 9'd6;
    endcase
  end

  always_comb begin
    crc_running_next  = crc_running;
    crc_frozen_next   = crc_frozen;
    crc_low_rx_next   = crc_low_rx;
    crc_mismatch_next = crc_mismatch;
    if (in_pdu && !tcp) begin
      if (p < 9'd2 || (kind != mfc_pkg::KIND_UNKNOWN && p < body)) begin
        crc_running_next = mfc_pkg::crc_byte(crc_running, rx);
      end else if (kind != mfc_pkg::KIND_UNKNOWN && p == body) begin
        crc_frozen_next = crc_running;
        crc_low_rx_next = rx;
      end else if (kind != mfc_pkg::KIND_UNKNOWN && p == body + 9'd1) begin
        crc_mismatch_next = ({rx, crc_low_rx} != crc_frozen);
      end
    end
  end

  assign has_data = in_pdu &&
                    ((kind == mfc_pkg::KIND_READ && p >= 9'd3 && p < body) ||
                     (kind == mfc_pkg::KIND_WRITE && p >= 9'd2 && p < 9'd6));
  assign idx_full = (kind == mfc_pkg::KIND_READ) ? p - 9'd3 : p - 9'd2;

  assign pos_next = (pos != mfc_pkg::POS_MAX) ? pos + 9'd1 : pos;
  assign got      = (pos_next > hdr) ? pos_next - hdr : 9'd0;
  assign need     = body + (tcp ? 9'd0 : 9'd2);

  always_comb begin
    cnt_full = 9'd0;
    exc_out  = 8'd0;
    if (got < 9'd2) begin
      st = mfc_pkg::ST_TOO_SHORT;
    end else if (kind == mfc_pkg::KIND_UNKNOWN) begin
      st = mfc_pkg::ST_UNKNOWN_FUNC;
    end else begin
      if (kind == mfc_pkg::KIND_READ && got > 9'd3) begin
        cnt_full = (got - 9'd3 < {1'b0, count_seen_next}) ? got - 9'd3
                                                          : {1'b0, count_seen_next};
      end else if (kind == mfc_pkg::KIND_WRITE && got > 9'd2) begin
        cnt_full = (got - 9'd2 < 9'd4) ? got - 9'd2 : 9'd4;
      end
      if (got < need) begin
        st = mfc_pkg::ST_TOO_SHORT;
      end else if (!tcp && crc_mismatch_next) begin
        st = mfc_pkg::ST_CRC_ERR;
      end else if (kind == mfc_pkg::KIND_EXCEPTION) begin
        st      = mfc_pkg::ST_EXCEPTION;
        exc_out = exc_seen_next;
      end else begin
        st = mfc_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    q_entry.has_data                  = has_data;
    q_entry.data_res.is_status        = 1'b0;
    q_entry.data_res.data_byte        = rx;
    q_entry.data_res.payload_index    = idx_full[7:0];
    q_entry.data_res.unit_address     = unit_seen_next;
    q_entry.data_res.function_code    = func_seen_next[6:0];
    q_entry.data_res.byte_count       = 8'd0;
    q_entry.data_res.exception_code   = 8'd0;
    q_entry.data_res.status           = mfc_pkg::ST_OK;
    q_entry.has_status                = in_data.frame_end;
    q_entry.status_res.is_status      = 1'b1;
    q_entry.status_res.data_byte      = 8'd0;
    q_entry.status_res.payload_index  = 8'd0;
    q_entry.status_res.unit_address   = unit_seen_next;
    q_entry.status_res.function_code  = func_seen_next[6:0];
    q_entry.status_res.byte_count     = cnt_full[7:0];
    q_entry.status_res.exception_code = exc_out;
    q_entry.status_res.status         = st;
  end

  assign q_push = accept && (has_data || in_data.frame_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= 1'b0;
    end else if (cfg_we) begin
      frame_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && in_data.frame_end)) begin
      pos          <= 9'd0;
      crc_running  <= mfc_pkg::CRC_INIT;
      crc_frozen   <= 16'd0;
      unit_seen    <= 8'd0;
      func_seen    <= 8'd0;
      count_seen   <= 8'd0;
      exc_seen     <= 8'd0;
      crc_low_rx   <= 8'd0;
      crc_mismatch <= 1'b0;
    end else if (accept) begin
      pos          <= pos_next;
      crc_running  <= crc_running_next;
      crc_frozen   <= crc_frozen_next;
      unit_seen    <= unit_seen_next;
      func_seen    <= func_seen_next;
      count_seen   <= count_seen_next;
      exc_seen     <= exc_seen_next;
      crc_low_rx   <= crc_low_rx_next;
      crc_mismatch <= crc_mismatch_next;
    end
  end

endmodule

>>> design/mfc_queue.sv
`timescale 1ns / 1ps

module mfc_queue #(
  parameter int DEPTH = mfc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mfc_pkg::entry_t push_entry,
  output logic            not_full,
  input  logic            pop,
  output logic            not_empty,
  output mfc_pkg::entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  mfc_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CW-1:0]   count;

  assign not_full  = (count != FULL);
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/mfc_back.sv
`timescale 1ns / 1ps

module mfc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  mfc_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output mfc_pkg::out_t   out_data
);

  logic data_done;
  logic take;
  logic emit_data;

  assign take      = q_not_empty && (!out_valid || out_ready);
  assign emit_data = q_head.has_data && !data_done;
  assign q_pop     = take && !(emit_data && q_head.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      data_done <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
      data_done <= emit_data && q_head.has_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= emit_data ? q_head.data_res : q_head.status_res;
    end
  end

endmodule

>>> design/modbus_response_frame_checker.sv
`timescale 1ns / 1ps
// Channel   Signals                           Beat
// config    cfg_we, cfg_wdata                 frame_mode, written when cfg_we is high
// input     in_valid, in_ready, in_data       one frame byte and its end flag
// output    out_valid, out_ready, out_data    one payload byte or one frame status
//
// One input byte is taken per cycle while the queue has room; the byte-wide CRC
// update finishes in that cycle. A frame's last byte may give two results (payload
// byte and status); the output register delivers one per cycle while out_ready is
// high, so such a byte takes two output beats. The queue between parser and output
// absorbs that and output stalls; input stalls only when it is full.
// Synchronous reset clears frame state, frame_mode and the queue; no clearing pass.

module modbus_response_frame_checker #(
  parameter int QUEUE_DEPTH = mfc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mfc_pkg::out_t out_data
);

  logic            q_push;
  logic            q_not_full;
  logic            q_pop;
  logic            q_not_empty;
  mfc_pkg::entry_t q_entry;
  mfc_pkg::entry_t q_head;

  mfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_ready   (q_not_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  mfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  mfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> design/mfc_checker.sv
`timescale 1ns / 1ps

module mfc_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input mfc_pkg::out_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");

  a_status_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_status |->
      out_data.data_byte == 8'd0 && out_data.payload_index == 8'd0)
    else $error("status beat carries payload");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_status |->
      out_data.status == mfc_pkg::ST_OK && out_data.byte_count == 8'd0 &&
      out_data.exception_code == 8'd0)
    else $error("payload beat carries status fields");

  a_exc_only_on_exception: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.exception_code != 8'd0 |->
      out_data.status == mfc_pkg::ST_EXCEPTION)
    else $error("exception code without exception status");

endmodule

bind modbus_response_frame_checker mfc_checker u_mfc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/modbus_response_frame_checker_test.sv
`timescale 1ns / 1ps

module modbus_response_frame_checker_test;
  import mfc_pkg::*;

  localparam int STUCK_LIMIT = 1000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t rx_bytes_q[$];
  out_t parsed_q[$];
  int errors = 0;
  int fed_bytes = 0;
  int in_hold = 0;
  int in_calm = 0;
  int out_hold = 0;
  int out_calm = 0;
  int stuck_cycles = 0;

  bit tcp_mode = 1'b0;
  logic [8:0] pos;
  logic [15:0] crc_acc;
  logic [15:0] crc_hold;
  logic [7:0] unit_r;
  logic [7:0] func_r;
  logic [7:0] count_r;
  logic [7:0] exc_r;
  logic [7:0] crc_lo;
  bit crc_bad;

  modbus_response_frame_checker dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic kind_t frame_kind(input logic [7:0] fc);
    if (fc[7]) return KIND_EXCEPTION;
    if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) return KIND_READ;
    if (fc == FC_WRITE_SINGLE || fc == FC_WRITE_MULTI) return KIND_WRITE;
    return KIND_UNKNOWN;
  endfunction

  function automatic int body_len(input kind_t k, input logic [7:0] cnt);
    if (k == KIND_EXCEPTION) return 3;
    if (k == KIND_READ) return 3 + int'(cnt);
    return 6;
  endfunction

  function automatic out_t make_result(input logic st, input logic [7:0] d, input logic [7:0] idx,
                                       input logic [7:0] cnt, input logic [7:0] exc,
                                       input status_t s);
    out_t r;
    r.is_status = st;
    r.data_byte = d;
    r.payload_index = idx;
    r.unit_address = unit_r;
    r.function_code = func_r[6:0];
    r.byte_count = cnt;
    r.exception_code = exc;
    r.status = s;
    return r;
  endfunction

  function automatic void restart_frame();
    pos = '0;
    crc_acc = CRC_INIT;
    crc_hold = '0;
    unit_r = '0;
    func_r = '0;
    count_r = '0;
    exc_r = '0;
    crc_lo = '0;
    crc_bad = 1'b0;
  endfunction

  task automatic parse_byte(input in_t b);
    logic [8:0] hdr;
    int p;
    int body;
    int got;
    int need;
    kind_t k;
    logic [7:0] cnt;
    logic [7:0] exc;
    status_t st;
    hdr = tcp_mode ? TCP_HDR : 9'd0;
    if (pos >= hdr) begin
      p = int'(pos) - int'(hdr);
      if (p == 0) begin
        unit_r = b.rx_byte;
      end else if (p == 1) begin
        func_r = b.rx_byte;
      end else if (p == 2) begin
        if (func_r[7]) begin
          exc_r = b.rx_byte;
        end else if (func_r == FC_READ_HOLDING || func_r == FC_READ_INPUT) begin
          count_r = b.rx_byte;
        end
      end
      k = frame_kind(func_r);
      body = body_len(k, count_r);
      if (!tcp_mode) begin
        if (p < 2 || (k != KIND_UNKNOWN && p < body)) begin
          crc_acc = crc_update(crc_acc, b.rx_byte);
        end else if (k != KIND_UNKNOWN && p == body) begin
          crc_hold = crc_acc;
          crc_lo = b.rx_byte;
        end else if (k != KIND_UNKNOWN && p == body + 1) begin
          crc_bad = ({b.rx_byte, crc_lo} != crc_hold);
        end
      end
      if (k == KIND_READ && p >= 3 && p < body) begin
        parsed_q.push_back(make_result(1'b0, b.rx_byte, 8'(p - 3), 8'd0, 8'd0, ST_OK));
      end else if (k == KIND_WRITE && p >= 2 && p < 6) begin
        parsed_q.push_back(make_result(1'b0, b.rx_byte, 8'(p - 2), 8'd0, 8'd0, ST_OK));
      end
    end
    if (pos < POS_MAX) pos++;
    if (b.frame_end) begin
      got = (pos > hdr) ? int'(pos - hdr) : 0;
      k = frame_kind(func_r);
      need = body_len(k, count_r) + (tcp_mode ? 0 : 2);
      cnt = '0;
      exc = '0;
      if (got < 2) begin
        st = ST_TOO_SHORT;
      end else if (k == KIND_UNKNOWN) begin
        st = ST_UNKNOWN_FUNC;
      end else begin
        if (k == KIND_READ && got > 3) begin
          cnt = (got - 3 < int'(count_r)) ? 8'(got - 3) : count_r;
        end else if (k == KIND_WRITE && got > 2) begin
          cnt = (got - 2 < 4) ? 8'(got - 2) : 8'd4;
        end
        if (got < need) begin
          st = ST_TOO_SHORT;
        end else if (!tcp_mode && crc_bad) begin
          st = ST_CRC_ERR;
        end else if (k == KIND_EXCEPTION) begin
          st = ST_EXCEPTION;
          exc = exc_r;
        end else begin
          st = ST_OK;
        end
      end
      parsed_q.push_back(make_result(1'b1, 8'd0, 8'd0, cnt, exc, st));
      restart_frame();
    end
  endtask

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  task automatic check_result(input out_t got);
    out_t want;
    if (parsed_q.size() == 0) begin
      $error("result beat with nothing expected: %p", got);
      errors++;
    end else begin
      want = parsed_q.pop_front();
      compare_field("is_status", 8'(want.is_status), 8'(got.is_status));
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("unit_address", want.unit_address, got.unit_address);
      compare_field("function_code", 8'(want.function_code), 8'(got.function_code));
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("exception_code", want.exception_code, got.exception_code);
      compare_field("status", 8'(want.status), 8'(got.status));
    end
  endtask

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic queue_frame(input bit tcp, input logic [7:0] fc, input int n_data,
                             input int cut, input bit bad_crc, input int tail);
    logic [7:0] fb[$];
    logic [15:0] crc;
    fb = {};
    fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(fc);
    if (fc[7]) begin
      fb.push_back(8'($urandom_range(0, 255)));
    end else if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
      fb.push_back(8'(n_data));
      repeat (n_data) fb.push_back(8'($urandom_range(0, 255)));
    end else if (fc == FC_WRITE_SINGLE || fc == FC_WRITE_MULTI) begin
      repeat (4) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 6)) fb.push_back(8'($urandom_range(0, 255)));
    end
    if (tcp) begin
      repeat (6) fb.push_front(8'($urandom_range(0, 255)));
    end else begin
      crc = CRC_INIT;
      foreach (fb[i]) crc = crc_update(crc, fb[i]);
      if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(0, 15));
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
    end
    repeat (tail) fb.push_back(8'($urandom_range(0, 255)));
    while (cut > 0 && fb.size() > 1) begin
      void'(fb.pop_back());
      cut--;
    end
    fed_bytes += fb.size();
    foreach (fb[i]) begin
      rx_bytes_q.push_back('{rx_byte: fb[i], frame_end: (i == fb.size() - 1)});
    end
  endtask

  task automatic queue_random_frame(input bit tcp);
    logic [7:0] fc;
    int sel;
    int n_data;
    int cut;
    int tail;
    bit bad_crc;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      fc = sel[0] ? FC_READ_INPUT : FC_READ_HOLDING;
    end else if (sel < 6) begin
      fc = sel[0] ? FC_WRITE_MULTI : FC_WRITE_SINGLE;
    end else if (sel < 8) begin
      fc = 8'h80 | 8'($urandom_range(0, 127));
    end else begin
      fc = FC_READ_HOLDING;
      while (frame_kind(fc) != KIND_UNKNOWN) begin
        case ($urandom_range(0, 7))
          0: fc = 8'h00;
          1: fc = 8'h7F;
          default: fc = 8'($urandom_range(0, 127));
        endcase
      end
    end
    n_data = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    cut = 0;
    tail = 0;
    bad_crc = 1'b0;
    sel = $urandom_range(0, 99);
    if (sel < 65) begin
    end else if (sel < 77) begin
      bad_crc = 1'b1;
    end else if (sel < 88) begin
      cut = $urandom_range(1, 4);
    end else if (sel < 95) begin
      tail = $urandom_range(1, 5);
    end else begin
      cut = $urandom_range(1, 12);
      bad_crc = 1'b1;
    end
    queue_frame(tcp, fc, n_data, cut, bad_crc, tail);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_valid || parsed_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    tcp_mode = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_hold = 0;
    end else begin
      if (in_valid && in_ready) parse_byte(in_data);
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          in_data <= rx_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_hold = idle_len(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_hold = idle_len(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (rx_bytes_q.size() == 0 && !in_valid && parsed_q.size() == 0)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    bit mode;
    int goal;
    restart_frame();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    queue_frame(1'b0, FC_READ_HOLDING, 2, 0, 1'b0, 0);
    queue_frame(1'b0, 8'h83, 0, 0, 1'b0, 0);
    queue_frame(1'b0, FC_WRITE_MULTI, 0, 0, 1'b1, 0);
    queue_frame(1'b0, FC_WRITE_SINGLE, 0, 3, 1'b0, 0);
    queue_frame(1'b0, 8'h7F, 0, 100, 1'b0, 0);
    queue_frame(1'b0, 8'h00, 0, 0, 1'b0, 0);
    queue_frame(1'b0, 8'hFF, 0, 0, 1'b0, 2);

    for (int ph = 1; ph <= 8; ph++) begin
      mode = (ph == 1) ? 1'b1 : (ph == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      wait_idle();
      write_mode(mode);
      if (ph == 3) queue_frame(mode, FC_READ_INPUT, 255, 0, 1'b0, 0);
      goal = fed_bytes + 10;
      while (fed_bytes < goal) queue_random_frame(mode);
      // leave a frame open across the next mode write
      if (ph < 8 && (ph == 4 || $urandom_range(0, 2) == 0)) begin
        repeat ($urandom_range(1, 8)) begin
          rx_bytes_q.push_back('{rx_byte: 8'($urandom_range(0, 255)), frame_end: 1'b0});
        end
      end
    end
    wait_idle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
